FILE: sv/brush_line_stroke_rasterizer_unit_defines.svh
// assertion helpers shared by the rasterizer rtl
`ifndef BRUSH_LINE_STROKE_RASTERIZER_UNIT_DEFINES_SVH
`define BRUSH_LINE_STROKE_RASTERIZER_UNIT_DEFINES_SVH

// property checked on every clock edge outside reset
`define BLSR_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// condition in one cycle implies a check in the following cycle
`define BLSR_ASSERT_NEXT(name, cond, chk, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (chk)) else $error(msg);

`endif

FILE: sv/blsr_pkg.sv
`timescale 1ns / 1ps

package blsr_pkg;

	localparam int COORD_BITS = 12;
	localparam int DELTA_W    = COORD_BITS + 1;
	localparam int PROD_W     = 2 * DELTA_W;
	localparam int BRUSH_W    = 7;
	localparam int FRAME_W    = 12;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CMP_W      = ((COORD_BITS > FRAME_W) ? COORD_BITS : FRAME_W) + 1;
	localparam int CNT_W      = $clog2(COORD_BITS);
	localparam int IN_DATA_W  = ((2 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((4 * COORD_BITS + 7) / 8) * 8;
	localparam int IN_USER_W  = 3;

	localparam logic [FRAME_W-1:0] FRAME_W_RST = FRAME_W'(640);
	localparam logic [FRAME_W-1:0] FRAME_H_RST = FRAME_W'(480);
	localparam logic [BRUSH_W-1:0] BRUSH_RST   = BRUSH_W'(1);

	typedef enum logic [1:0] {
		FN_PRESS   = 2'd0,
		FN_MOTION  = 2'd1,
		FN_RELEASE = 2'd2,
		FN_STEP    = 2'd3
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BRUSH_SIZE   = 2'd0,
		CFG_FRAME_WIDTH  = 2'd1,
		CFG_FRAME_HEIGHT = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_ABS,
		ST_DIV,
		ST_EMIT
	} state_t;

endpackage

FILE: sv/brush_line_stroke_rasterizer_unit.sv
`timescale 1ns / 1ps
`include "brush_line_stroke_rasterizer_unit_defines.svh"

// Pointer events in, square brush stamps out. The block takes one input transfer at a
// time and holds s_axis_tready low until that item is finished. Motion and release
// items and any item that gives no stamp finish in ST_IDLE. A press that stamps goes
// to ST_EMIT, which loads the output register. A step item goes through ST_MUL1,
// ST_MUL2, ST_ABS, ST_DIV and ST_EMIT: two passes through one shared 13x13 signed
// multiplier build the intercept numerator, ST_ABS takes its magnitude, a restoring
// divider retires one quotient bit per cycle for COORD_BITS (12) bits, and ST_EMIT
// forms the stamp rectangle once the output register is free; s_axis_tready returns in
// the cycle after that. A quotient that falls outside the coordinate range gives an
// invalid stamp. The result waits in an output register, so the next item is taken
// while a stamp is still unclaimed; only a second stamp stalls behind it.
module brush_line_stroke_rasterizer_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [blsr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [blsr_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// pos_x, pos_y
	input  logic [blsr_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// func, left_held
	input  logic [blsr_pkg::IN_USER_W-1:0]   s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// x_first, x_last, y_first, y_last
	output logic [blsr_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// stamp_valid
	output logic                             m_axis_tuser,
	// segment_done
	output logic                             m_axis_tlast
);
	import blsr_pkg::*;

	localparam int CW = COORD_BITS;

	state_t state_q, state_d;

	logic [BRUSH_W-1:0] brush_q;
	logic [FRAME_W-1:0] frame_w_q;
	logic [FRAME_W-1:0] frame_h_q;

	logic [CW-1:0] last_x_q, last_y_q;
	logic          pen_down_q;
	logic          seg_active_q;
	logic          seg_steep_q;
	logic [CW-1:0] seg_start_x_q, seg_start_y_q;
	logic signed [DELTA_W-1:0] seg_dx_q, seg_dy_q;
	logic [CW-1:0] seg_index_q, seg_end_q;

	logic [CW-1:0] major_q;
	logic          done_q;
	logic          bad_q;
	logic [CW-1:0] cx_q, cy_q;
	logic signed [PROD_W-1:0] acc_q;
	logic [CW-1:0] rem_q, lo_q, div_q;
	logic [CNT_W-1:0] cnt_q;

	logic [CW-1:0] x_first_q, x_last_q, y_first_q, y_last_q;

	func_t   in_func;
	logic    in_held;
	logic [CW-1:0] in_x, in_y;
	logic    in_xfer;
	logic    emit_go;
	logic    press_in_frame;

	assign in_func = func_t'(s_axis_tuser[1:0]);
	assign in_held = s_axis_tuser[2];
	assign in_x    = s_axis_tdata[CW-1:0];
	assign in_y    = s_axis_tdata[2*CW-1:CW];
	assign in_xfer = s_axis_tvalid && s_axis_tready;

	assign press_in_frame = (CMP_W'(in_x) < CMP_W'(frame_w_q))
		&& (CMP_W'(in_y) < CMP_W'(frame_h_q));

	// motion geometry
	logic signed [DELTA_W-1:0] mv_dx, mv_dy, mv_adx, mv_ady;
	logic          mv_steep;
	logic [CW-1:0] mv_lo, mv_hi;

	always_comb begin
		mv_dx = $signed({1'b0, in_x}) - $signed({1'b0, last_x_q});
		mv_dy = $signed({1'b0, in_y}) - $signed({1'b0, last_y_q});
		mv_adx = mv_dx[DELTA_W-1] ? -mv_dx : mv_dx;
		mv_ady = mv_dy[DELTA_W-1] ? -mv_dy : mv_dy;
		mv_steep = !(mv_adx > mv_ady);
		if (!mv_steep) begin
			mv_lo = (in_x < last_x_q) ? in_x : last_x_q;
			mv_hi = (in_x < last_x_q) ? last_x_q : in_x;
		end else begin
			mv_lo = (in_y < last_y_q) ? in_y : last_y_q;
			mv_hi = (in_y < last_y_q) ? last_y_q : in_y;
		end
	end

	// shared multiplier operands: minor_start*d_major, then d_minor*(i - major_start)
	logic [CW-1:0] min_start, maj_start;
	logic signed [DELTA_W-1:0] d_maj, d_min, mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;
	logic [CW-1:0] seg_next;

	always_comb begin
		min_start = seg_steep_q ? seg_start_x_q : seg_start_y_q;
		maj_start = seg_steep_q ? seg_start_y_q : seg_start_x_q;
		d_maj     = seg_steep_q ? seg_dy_q : seg_dx_q;
		d_min     = seg_steep_q ? seg_dx_q : seg_dy_q;
		if (state_q == ST_MUL1) begin
			mul_a = $signed({1'b0, min_start});
			mul_b = d_maj;
		end else begin
			mul_a = d_min;
			mul_b = $signed({1'b0, major_q}) - $signed({1'b0, maj_start});
		end
		prod = mul_a * mul_b;
	end

	assign seg_next = seg_index_q + CW'(1);

	// numerator magnitude and divisor magnitude
	logic signed [PROD_W-1:0] acc_mag;
	logic signed [DELTA_W-1:0] d_maj_mag;
	logic          div_zero, div_ovf, quo_neg;

	assign acc_mag   = acc_q[PROD_W-1] ? -acc_q : acc_q;
	assign d_maj_mag = d_maj[DELTA_W-1] ? -d_maj : d_maj;
	// a steep flag written by a later motion that starts no segment can give a zero divisor or a
	// quotient outside the coordinate range
	assign div_zero  = (d_maj == '0);
	assign div_ovf   = acc_mag[PROD_W-1:CW] >= (PROD_W - CW)'(d_maj_mag[CW-1:0]);
	assign quo_neg   = acc_q[PROD_W-1] ^ d_maj[DELTA_W-1];

	// one restoring division step
	logic [CW:0]   div_trial;
	logic          div_bit;
	logic [CW-1:0] rem_next, lo_next;

	always_comb begin
		div_trial = {rem_q, lo_q[CW-1]};
		div_bit   = div_trial >= {1'b0, div_q};
		rem_next  = div_bit ? CW'(div_trial - {1'b0, div_q}) : div_trial[CW-1:0];
		lo_next   = {lo_q[CW-2:0], div_bit};
	end

	// stamp rectangle from the center
	logic [CW-1:0]    brush_c;
	logic [CMP_W-1:0] x_end, y_end;
	logic             stamp_ok;

	always_comb begin
		brush_c = CW'(brush_q);
		x_end = CMP_W'(cx_q) + CMP_W'(brush_q) - CMP_W'(1);
		y_end = CMP_W'(cy_q) + CMP_W'(brush_q) - CMP_W'(1);
		stamp_ok = (brush_q != '0) && !bad_q
			&& (CMP_W'(cx_q) >= CMP_W'(brush_q))
			&& (CMP_W'(cy_q) >= CMP_W'(brush_q))
			&& (x_end < CMP_W'(frame_w_q))
			&& (y_end < CMP_W'(frame_h_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		emit_go       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					case (in_func)
						FN_PRESS: begin
							if (in_held && press_in_frame) begin
								state_d = ST_EMIT;
							end
						end
						FN_STEP: begin
							if (seg_active_q) begin
								state_d = ST_MUL1;
							end
						end
						default: ;
					endcase
				end
			end
			ST_MUL1: state_d = ST_MUL2;
			ST_MUL2: state_d = ST_ABS;
			ST_ABS:  state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == CNT_W'(CW - 1)) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!m_axis_tvalid || m_axis_tready) begin
					emit_go = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// configuration and pen / segment state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brush_q       <= BRUSH_RST;
			frame_w_q     <= FRAME_W_RST;
			frame_h_q     <= FRAME_H_RST;
			last_x_q      <= '0;
			last_y_q      <= '0;
			pen_down_q    <= 1'b0;
			seg_active_q  <= 1'b0;
			seg_steep_q   <= 1'b0;
			seg_start_x_q <= '0;
			seg_start_y_q <= '0;
			seg_dx_q      <= '0;
			seg_dy_q      <= '0;
			seg_index_q   <= '0;
			seg_end_q     <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_BRUSH_SIZE:   brush_q   <= cfg_data[BRUSH_W-1:0];
					CFG_FRAME_WIDTH:  frame_w_q <= cfg_data[FRAME_W-1:0];
					CFG_FRAME_HEIGHT: frame_h_q <= cfg_data[FRAME_W-1:0];
					default: ;
				endcase
			end
			if (in_xfer) begin
				case (in_func)
					FN_PRESS: begin
						if (in_held) begin
							pen_down_q   <= 1'b1;
							seg_active_q <= 1'b0;
							last_x_q     <= in_x;
							last_y_q     <= in_y;
						end
					end
					FN_MOTION: begin
						if (pen_down_q) begin
							seg_steep_q <= mv_steep;
							if (mv_lo < mv_hi) begin
								seg_active_q  <= 1'b1;
								seg_start_x_q <= last_x_q;
								seg_start_y_q <= last_y_q;
								seg_dx_q      <= mv_dx;
								seg_dy_q      <= mv_dy;
								seg_index_q   <= mv_lo;
								seg_end_q     <= mv_hi;
							end
							last_x_q <= in_x;
							last_y_q <= in_y;
						end
					end
					FN_RELEASE: pen_down_q <= 1'b0;
					FN_STEP: begin
						if (seg_active_q) begin
							seg_index_q <= seg_next;
							if (seg_next >= seg_end_q) begin
								seg_active_q <= 1'b0;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	// working registers of the step sequence
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			if (in_func == FN_PRESS) begin
				cx_q   <= in_x;
				cy_q   <= in_y;
				done_q <= 1'b1;
				bad_q  <= 1'b0;
			end else begin
				major_q <= seg_index_q;
				done_q  <= seg_next >= seg_end_q;
			end
		end
		case (state_q)
			ST_MUL1: acc_q <= prod;
			ST_MUL2: acc_q <= acc_q + prod;
			ST_ABS: begin
				// a zero divisor keeps the minor start: divide it by one
				rem_q <= (div_zero || div_ovf) ? '0 : acc_mag[2*CW-1:CW];
				lo_q  <= div_zero ? min_start : acc_mag[CW-1:0];
				div_q <= div_zero ? CW'(1) : d_maj_mag[CW-1:0];
				bad_q <= !div_zero && (div_ovf || quo_neg);
				cnt_q <= '0;
			end
			ST_DIV: begin
				rem_q <= rem_next;
				lo_q  <= lo_next;
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(CW - 1)) begin
					cx_q <= seg_steep_q ? lo_next : major_q;
					cy_q <= seg_steep_q ? major_q : lo_next;
				end
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (emit_go) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			m_axis_tuser <= stamp_ok;
			m_axis_tlast <= done_q;
			x_first_q    <= stamp_ok ? cx_q - brush_c : '0;
			x_last_q     <= stamp_ok ? cx_q + brush_c - CW'(2) : '0;
			y_first_q    <= stamp_ok ? cy_q - brush_c : '0;
			y_last_q     <= stamp_ok ? cy_q + brush_c - CW'(2) : '0;
		end
	end

	assign m_axis_tdata = OUT_DATA_W'({y_last_q, y_first_q, x_last_q, x_first_q});

	`BLSR_ASSERT(a_rem_below_div, (state_q == ST_DIV) |-> (rem_q < div_q), "division remainder not below divisor")
	`BLSR_ASSERT_NEXT(a_div_nonzero, (state_q == ST_ABS), (div_q != '0), "segment divisor is zero")
	`BLSR_ASSERT(a_stamp_order, (m_axis_tvalid && m_axis_tuser) |-> ((x_first_q <= x_last_q) && (y_first_q <= y_last_q)), "stamp rectangle inverted")
	`BLSR_ASSERT(a_seg_range, (seg_active_q && (state_q == ST_IDLE)) |-> (seg_index_q < seg_end_q), "pending segment has no stamps left")

endmodule
